/* rtl/dspo_pkg.sv */
// Package: shared constants, types and the CORDIC arctangent table.
package dspo_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int FRAC_BITS = 16;
	localparam int NSTEP = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
	localparam int STEP_W = $clog2(NSTEP + 1);
	localparam int VW = 72;
	localparam int GUARD_SHIFT = 8;
	localparam logic [31:0] KQ_FULL = 32'h9B74EDA8;
	localparam logic signed [VW-1:0] KQ = VW'(KQ_FULL >> (32 - FRAC_BITS));

	localparam logic [1:0] REG_MOUNT_A_X = 2'd0;
	localparam logic [1:0] REG_MOUNT_A_Y = 2'd1;
	localparam logic [1:0] REG_MOUNT_B_X = 2'd2;
	localparam logic [1:0] REG_MOUNT_B_Y = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ANG0_INIT, ST_ANG0_RUN, ST_ANG1_INIT, ST_ANG1_RUN,
		ST_ROT_INIT, ST_ROT_SCALE, ST_ROT_RUN, ST_ACC, ST_QUAT_INIT,
		ST_QUAT_SCALE, ST_QUAT_RUN, ST_QUAT_DONE, ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE, CMD_LOAD, CMD_ANG0_INIT, CMD_ANG1_INIT, CMD_ROT_INIT,
		CMD_SCALE, CMD_ANG_STEP, CMD_ANG1_STEP, CMD_ROT_STEP, CMD_ACC,
		CMD_QUAT_INIT, CMD_QUAT_DONE, CMD_PUSH
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic step_clr;
	} ctl_t;

	typedef struct packed {
		logic last_step;
	} sts_t;

	function automatic logic [31:0] atan_tab(input logic [4:0] i);
		logic [31:0] r;
		begin
			unique case (i)
				5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E;
				5'd2: r = 32'h09FB385B; 5'd3: r = 32'h051111D4;
				5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
				5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55;
				5'd8: r = 32'h0028BE53; 5'd9: r = 32'h00145F2F;
				5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
				5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
				5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
				5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
				5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
				5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
				5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
				5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
				5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
				5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
				5'd30: r = 32'h00000001;
				default: r = 32'h00000000;
			endcase
			return r;
		end
	endfunction

endpackage

/* rtl/dspo_if.sv */
// Interfaces: sensor item, pose result and configuration write channels.
interface dspo_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] first_x;
	logic signed [31:0] first_y;
	logic signed [31:0] second_x;
	logic signed [31:0] second_y;
	modport source (output valid, first_x, first_y, second_x, second_y, input ready);
	modport sink (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface dspo_out_if;
	logic valid;
	logic ready;
	logic signed [47:0] pose_x;
	logic signed [47:0] pose_y;
	logic [31:0] heading;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;
	modport source (output valid, pose_x, pose_y, heading, quat_z, quat_w, input ready);
	modport sink (input valid, pose_x, pose_y, heading, quat_z, quat_w, output ready);
endinterface

interface dspo_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [23:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/dspo_ctrl.sv */
// Controller: sequences the CORDIC passes for one item and the result handshake.
module dspo_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_fire,
	input  dspo_pkg::sts_t sts,
	output dspo_pkg::ctl_t ctl,
	output logic in_ready,
	output logic out_valid
);
	dspo_pkg::state_t state_q, state_nx;
	logic out_valid_q;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dspo_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Track the result register: fill on push, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.cmd == dspo_pkg::CMD_PUSH) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		ctl.cmd = dspo_pkg::CMD_NONE;
		ctl.step_clr = 1'b0;
		in_ready = 1'b0;
		unique case (state_q)
			dspo_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					ctl.cmd = dspo_pkg::CMD_LOAD;
					state_nx = dspo_pkg::ST_ANG0_INIT;
				end
			end
			dspo_pkg::ST_ANG0_INIT: begin
				ctl.cmd = dspo_pkg::CMD_ANG0_INIT;
				ctl.step_clr = 1'b1;
				state_nx = dspo_pkg::ST_ANG0_RUN;
			end
			dspo_pkg::ST_ANG0_RUN: begin
				ctl.cmd = dspo_pkg::CMD_ANG_STEP;
				if (sts.last_step) state_nx = dspo_pkg::ST_ANG1_INIT;
			end
			dspo_pkg::ST_ANG1_INIT: begin
				ctl.cmd = dspo_pkg::CMD_ANG1_INIT;
				ctl.step_clr = 1'b1;
				state_nx = dspo_pkg::ST_ANG1_RUN;
			end
			dspo_pkg::ST_ANG1_RUN: begin
				ctl.cmd = dspo_pkg::CMD_ANG1_STEP;
				if (sts.last_step) state_nx = dspo_pkg::ST_ROT_INIT;
			end
			dspo_pkg::ST_ROT_INIT: begin
				ctl.cmd = dspo_pkg::CMD_ROT_INIT;
				state_nx = dspo_pkg::ST_ROT_SCALE;
			end
			dspo_pkg::ST_ROT_SCALE: begin
				ctl.cmd = dspo_pkg::CMD_SCALE;
				ctl.step_clr = 1'b1;
				state_nx = dspo_pkg::ST_ROT_RUN;
			end
			dspo_pkg::ST_ROT_RUN: begin
				ctl.cmd = dspo_pkg::CMD_ROT_STEP;
				if (sts.last_step) state_nx = dspo_pkg::ST_ACC;
			end
			dspo_pkg::ST_ACC: begin
				ctl.cmd = dspo_pkg::CMD_ACC;
				state_nx = dspo_pkg::ST_QUAT_INIT;
			end
			dspo_pkg::ST_QUAT_INIT: begin
				ctl.cmd = dspo_pkg::CMD_QUAT_INIT;
				state_nx = dspo_pkg::ST_QUAT_SCALE;
			end
			dspo_pkg::ST_QUAT_SCALE: begin
				ctl.cmd = dspo_pkg::CMD_SCALE;
				ctl.step_clr = 1'b1;
				state_nx = dspo_pkg::ST_QUAT_RUN;
			end
			dspo_pkg::ST_QUAT_RUN: begin
				ctl.cmd = dspo_pkg::CMD_ROT_STEP;
				if (sts.last_step) state_nx = dspo_pkg::ST_QUAT_DONE;
			end
			dspo_pkg::ST_QUAT_DONE: begin
				ctl.cmd = dspo_pkg::CMD_QUAT_DONE;
				state_nx = dspo_pkg::ST_OUT;
			end
			dspo_pkg::ST_OUT: begin
				// Push into the result register once it is free
				if (!out_valid_q || out_fire) begin
					ctl.cmd = dspo_pkg::CMD_PUSH;
					state_nx = dspo_pkg::ST_IDLE;
				end
			end
			default: state_nx = dspo_pkg::ST_IDLE;
		endcase
	end
endmodule

/* rtl/dspo_dp.sv */
// Datapath: step differencing, shared CORDIC unit, pose and heading accumulators.
module dspo_dp (
	input  logic clk,
	input  logic arst_n,
	input  dspo_pkg::ctl_t ctl,
	output dspo_pkg::sts_t sts,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [23:0] cfg_data,
	input  logic signed [31:0] first_x,
	input  logic signed [31:0] first_y,
	input  logic signed [31:0] second_x,
	input  logic signed [31:0] second_y,
	output logic signed [47:0] pose_x,
	output logic signed [47:0] pose_y,
	output logic [31:0] heading,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w
);
	localparam int VW = dspo_pkg::VW;
	localparam logic signed [47:0] SAT_HI = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] SAT_LO = {1'b1, {47{1'b0}}};

	logic signed [23:0] ma_x_q, ma_y_q, mb_x_q, mb_y_q;
	logic signed [31:0] p1x_q, p1y_q, p2x_q, p2y_q;
	logic signed [32:0] d1x_q, d1y_q, d2x_q, d2y_q;
	logic signed [47:0] acc_x_q, acc_y_q;
	logic [31:0] acc_h_q, ang0_q;
	logic signed [VW-1:0] x_q, y_q, mx_q, my_q;
	logic [31:0] z_q;
	logic [dspo_pkg::STEP_W-1:0] step_q;
	logic signed [15:0] qz_q, qw_q;
	logic zero_q;
	logic signed [47:0] out_px_q, out_py_q;
	logic [31:0] out_h_q;
	logic signed [15:0] out_qz_q, out_qw_q;

	logic signed [VW-1:0] dx, dy, ox, oy;
	logic [31:0] tab;
	logic ydir, zdir;
	logic [31:0] z_vec;
	logic signed [35:0] blx, bly, b0x, b0y;
	logic signed [VW-1:0] ax, ay;
	logic [31:0] rot_a;
	logic signed [VW-1:0] rx0, ry0;
	logic signed [48:0] sx, sy;
	logic signed [VW-1:0] qw_w, qz_w;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ma_x_q <= '0; ma_y_q <= '0; mb_x_q <= '0; mb_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dspo_pkg::REG_MOUNT_A_X: ma_x_q <= cfg_data;
				dspo_pkg::REG_MOUNT_A_Y: ma_y_q <= cfg_data;
				dspo_pkg::REG_MOUNT_B_X: mb_x_q <= cfg_data;
				dspo_pkg::REG_MOUNT_B_Y: mb_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Step shared by vectoring and rotation
	assign tab = dspo_pkg::atan_tab(5'(step_q));
	assign dx = x_q >>> step_q;
	assign dy = y_q >>> step_q;
	assign ydir = (y_q > 0);
	assign zdir = !z_q[31];
	assign sts.last_step = (step_q == dspo_pkg::STEP_W'(dspo_pkg::NSTEP - 1));
	// Vectoring angle update; a zero vector keeps angle 0
	assign z_vec = zero_q ? z_q : (ydir ? z_q + tab : z_q - tab);

	// Baselines
	assign b0x = 36'(mb_x_q) - 36'(ma_x_q);
	assign b0y = 36'(mb_y_q) - 36'(ma_y_q);
	assign blx = b0x + 36'(d2x_q) - 36'(d1x_q);
	assign bly = b0y + 36'(d2y_q) - 36'(d1y_q);
	assign ax = (ctl.cmd == dspo_pkg::CMD_ANG0_INIT) ? VW'(b0x) : VW'(blx);
	assign ay = (ctl.cmd == dspo_pkg::CMD_ANG0_INIT) ? VW'(b0y) : VW'(bly);

	// Rotation setup: quadrant fold
	assign rot_a = (ctl.cmd == dspo_pkg::CMD_QUAT_INIT) ? {1'b0, acc_h_q[31:1]} : acc_h_q;
	assign rx0 = (ctl.cmd == dspo_pkg::CMD_QUAT_INIT) ? VW'(32768) : mx_q;
	assign ry0 = (ctl.cmd == dspo_pkg::CMD_QUAT_INIT) ? '0 : my_q;

	// Rounded outputs and saturation
	assign ox = (x_q + VW'(128)) >>> dspo_pkg::GUARD_SHIFT;
	assign oy = (y_q + VW'(128)) >>> dspo_pkg::GUARD_SHIFT;
	assign sx = 49'(acc_x_q) + 49'(ox);
	assign sy = 49'(acc_y_q) + 49'(oy);
	assign qw_w = ox;
	assign qz_w = oy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1x_q <= '0; p1y_q <= '0; p2x_q <= '0; p2y_q <= '0;
			acc_x_q <= '0; acc_y_q <= '0; acc_h_q <= '0;
			out_px_q <= '0; out_py_q <= '0; out_h_q <= '0;
			out_qz_q <= '0; out_qw_q <= '0;
		end else begin
			if (ctl.cmd == dspo_pkg::CMD_LOAD) begin
				p1x_q <= first_x; p1y_q <= first_y;
				p2x_q <= second_x; p2y_q <= second_y;
			end
			if (ctl.cmd == dspo_pkg::CMD_ANG1_STEP && sts.last_step) begin
				acc_h_q <= acc_h_q;
			end
			if (ctl.cmd == dspo_pkg::CMD_ACC) begin
				acc_x_q <= (sx > 49'(SAT_HI)) ? SAT_HI : (sx < 49'(SAT_LO)) ? SAT_LO : 48'(sx);
				acc_y_q <= (sy > 49'(SAT_HI)) ? SAT_HI : (sy < 49'(SAT_LO)) ? SAT_LO : 48'(sy);
				acc_h_q <= acc_h_q + ang0_q;
			end
			// Load the result register
			if (ctl.cmd == dspo_pkg::CMD_PUSH) begin
				out_px_q <= acc_x_q; out_py_q <= acc_y_q; out_h_q <= acc_h_q;
				out_qz_q <= qz_q; out_qw_q <= qw_q;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (ctl.step_clr) step_q <= '0;
		else step_q <= step_q + 1'b1;
		case (ctl.cmd)
			dspo_pkg::CMD_LOAD: begin
				d1x_q <= 33'(first_x) - 33'(p1x_q);
				d1y_q <= 33'(first_y) - 33'(p1y_q);
				d2x_q <= 33'(second_x) - 33'(p2x_q);
				d2y_q <= 33'(second_y) - 33'(p2y_q);
			end
			dspo_pkg::CMD_ANG0_INIT, dspo_pkg::CMD_ANG1_INIT: begin
				if (ctl.cmd == dspo_pkg::CMD_ANG1_INIT) ang0_q <= z_q;
				if (ax[VW-1]) begin
					x_q <= -(ax <<< 8); y_q <= -(ay <<< 8); z_q <= 32'h80000000;
				end else begin
					x_q <= ax <<< 8; y_q <= ay <<< 8; z_q <= '0;
				end
				// zero vector holds angle 0 through all steps
				zero_q <= (ax == '0 && ay == '0);
				mx_q <= VW'((34'(d1x_q) + 34'(d2x_q)) >>> 1);
				my_q <= VW'((34'(d1y_q) + 34'(d2y_q)) >>> 1);
			end
			dspo_pkg::CMD_ANG_STEP, dspo_pkg::CMD_ANG1_STEP: begin
				if (!zero_q) begin
					if (ydir) begin
						x_q <= x_q + dy; y_q <= y_q - dx;
					end else begin
						x_q <= x_q - dy; y_q <= y_q + dx;
					end
				end
				z_q <= z_vec;
				if (ctl.cmd == dspo_pkg::CMD_ANG1_STEP && sts.last_step)
					ang0_q <= z_vec - ang0_q;
			end
			dspo_pkg::CMD_ROT_INIT, dspo_pkg::CMD_QUAT_INIT: begin
				if (rot_a[31] != rot_a[30]) begin
					x_q <= -rx0; y_q <= -ry0; z_q <= rot_a + 32'h80000000;
				end else begin
					x_q <= rx0; y_q <= ry0; z_q <= rot_a;
				end
			end
			dspo_pkg::CMD_SCALE: begin
				x_q <= ((x_q * dspo_pkg::KQ) >>> dspo_pkg::FRAC_BITS) <<< 8;
				y_q <= ((y_q * dspo_pkg::KQ) >>> dspo_pkg::FRAC_BITS) <<< 8;
			end
			dspo_pkg::CMD_ROT_STEP: begin
				if (zdir) begin
					x_q <= x_q - dy; y_q <= y_q + dx; z_q <= z_q - tab;
				end else begin
					x_q <= x_q + dy; y_q <= y_q - dx; z_q <= z_q + tab;
				end
			end
			dspo_pkg::CMD_QUAT_DONE: begin
				qw_q <= (qw_w > VW'(32767)) ? 16'sh7FFF : (qw_w < -VW'(32768)) ? 16'sh8000 : 16'(qw_w);
				qz_q <= (qz_w > VW'(32767)) ? 16'sh7FFF : (qz_w < -VW'(32768)) ? 16'sh8000 : 16'(qz_w);
			end
			default: ;
		endcase
	end

	assign pose_x = out_px_q;
	assign pose_y = out_py_q;
	assign heading = out_h_q;
	assign quat_z = out_qz_q;
	assign quat_w = out_qw_q;
endmodule

/* rtl/dual_sensor_planar_odometry.sv */
// Top level: planar odometry from two displacement sensors.
// The block takes no new item until the current one is pushed; the shared CORDIC unit runs four
// passes (two vectoring, two rotation) of NSTEP iterations each. A result waiting
// in the output register stalls the next item only when that item is finished too.
// Reset: asynchronous; clears mounts, previous readings, pose and heading to zero.
module dual_sensor_planar_odometry (
	input logic clk,
	input logic arst_n,
	dspo_in_if.sink  in_ch,
	dspo_out_if.source out_ch,
	dspo_cfg_if.sink cfg
);
	dspo_pkg::ctl_t ctl;
	dspo_pkg::sts_t sts;
	logic in_fire, out_fire;

	assign cfg.ready = 1'b1;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;

	dspo_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.sts(sts), .ctl(ctl), .in_ready(in_ch.ready), .out_valid(out_ch.valid)
	);

	dspo_dp u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
		.first_x(in_ch.first_x), .first_y(in_ch.first_y),
		.second_x(in_ch.second_x), .second_y(in_ch.second_y),
		.pose_x(out_ch.pose_x), .pose_y(out_ch.pose_y), .heading(out_ch.heading),
		.quat_z(out_ch.quat_z), .quat_w(out_ch.quat_w)
	);

	// Result stays offered until its transfer
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("valid dropped");
	// Result heading holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(out_ch.heading))
		else $error("result changed while stalled");
	// Transfer in leaves the idle state
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ch.ready) else $error("accepted twice");
endmodule

/* bench/tb_top.sv */
// Testbench for the two-sensor planar odometry block: pose predictor and result checks.
module tb_top;

	localparam int HALF_PERIOD = 2;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 3 * dspo_pkg::NSTEP + 16;
	localparam int LONG_HOLD = 400;

	// Expected pose result
	typedef struct {
		logic signed [47:0] pose_x;
		logic signed [47:0] pose_y;
		logic [31:0] heading;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} pose_rec_t;

	// Odometry predictor plus the store of pending pose results
	class odo_scoreboard;
		bit signed [23:0] mnt_ax, mnt_ay, mnt_bx, mnt_by;
		bit signed [31:0] last_fx, last_fy, last_sx, last_sy;
		longint pos_x, pos_y;
		bit [31:0] yaw;
		pose_rec_t want_q[$];
		int errors;
		int results_seen;
		bit [31:0] arc_tab[32];

		function new();
			arc_tab = '{
				32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
				32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
				32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
				32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
				32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
				32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
				32'h00000001, 32'h00000000};
			mnt_ax = 0; mnt_ay = 0; mnt_bx = 0; mnt_by = 0;
			last_fx = 0; last_fy = 0; last_sx = 0; last_sy = 0;
			pos_x = 0; pos_y = 0; yaw = 0;
			errors = 0;
			results_seen = 0;
		endfunction

		function void set_mount(logic [1:0] idx, logic [23:0] val);
			case (idx)
				dspo_pkg::REG_MOUNT_A_X: mnt_ax = val;
				dspo_pkg::REG_MOUNT_A_Y: mnt_ay = val;
				dspo_pkg::REG_MOUNT_B_X: mnt_bx = val;
				dspo_pkg::REG_MOUNT_B_Y: mnt_by = val;
			endcase
		endfunction

		// Vectoring: binary angle of (x, y)
		function bit [31:0] vec_angle(longint x, longint y);
			bit [31:0] ang;
			longint dx, dy;
			ang = 0;
			if (x == 0 && y == 0)
				return 0;
			x = x * 256;
			y = y * 256;
			if (x < 0) begin
				x = -x;
				y = -y;
				ang = 32'h80000000;
			end
			for (int i = 0; i < dspo_pkg::NSTEP; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y > 0) begin
					x += dx; y -= dy; ang += arc_tab[i];
				end else begin
					x -= dx; y += dy; ang -= arc_tab[i];
				end
			end
			return ang;
		endfunction

		// Rotation of (x, y) by binary angle a, gain compensated
		function void turn_vec(longint x, longint y, bit [31:0] a, output longint ox,
				output longint oy);
			longint gain, z, dx, dy;
			bit [31:0] q;
			gain = longint'(64'h9B74EDA8 >> (32 - dspo_pkg::FRAC_BITS));
			q = a + 32'h40000000;
			if (q[31]) begin
				x = -x;
				y = -y;
				a += 32'h80000000;
			end
			z = longint'($signed(a));
			x = ((x * gain) >>> dspo_pkg::FRAC_BITS) * 256;
			y = ((y * gain) >>> dspo_pkg::FRAC_BITS) * 256;
			for (int i = 0; i < dspo_pkg::NSTEP; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(arc_tab[i]);
				end else begin
					x += dx; y -= dy; z += longint'(arc_tab[i]);
				end
			end
			ox = (x + 128) >>> 8;
			oy = (y + 128) >>> 8;
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			return (v > hi) ? hi : ((v < lo) ? lo : v);
		endfunction

		// Advance the pose for one accepted sensor transfer
		function void note_item(bit signed [31:0] fx, bit signed [31:0] fy,
				bit signed [31:0] sx, bit signed [31:0] sy);
			longint ax, ay, bx, by, d1x, d1y, d2x, d2y, mx, my, rx, ry, qw, qz;
			bit [31:0] turn;
			pose_rec_t r;
			ax = mnt_ax; ay = mnt_ay; bx = mnt_bx; by = mnt_by;
			d1x = longint'(fx) - longint'(last_fx);
			d1y = longint'(fy) - longint'(last_fy);
			d2x = longint'(sx) - longint'(last_sx);
			d2y = longint'(sy) - longint'(last_sy);
			last_fx = fx; last_fy = fy; last_sx = sx; last_sy = sy;
			turn = vec_angle((bx + d2x) - (ax + d1x), (by + d2y) - (ay + d1y))
				- vec_angle(bx - ax, by - ay);
			mx = (d1x + d2x) >>> 1;
			my = (d1y + d2y) >>> 1;
			turn_vec(mx, my, yaw, rx, ry);
			pos_x = clamp(pos_x + rx, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
			pos_y = clamp(pos_y + ry, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
			yaw += turn;
			turn_vec(32768, 0, yaw >> 1, qw, qz);
			r.pose_x = pos_x[47:0];
			r.pose_y = pos_y[47:0];
			r.heading = yaw;
			r.quat_z = clamp(qz, -32768, 32767);
			r.quat_w = clamp(qw, -32768, 32767);
			want_q.push_back(r);
		endfunction

		function void report(string fld, longint exp_v, longint act_v);
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, fld, exp_v, act_v);
			errors++;
		endfunction

		// Compare one accepted pose transfer with the oldest prediction
		function void check_result(pose_rec_t got);
			pose_rec_t w;
			results_seen++;
			if (want_q.size() == 0) begin
				$display("%0t: unexpected result, heading %0h", $time, got.heading);
				errors++;
				return;
			end
			w = want_q.pop_front();
			if (got.pose_x !== w.pose_x) report("pose_x", w.pose_x, got.pose_x);
			if (got.pose_y !== w.pose_y) report("pose_y", w.pose_y, got.pose_y);
			if (got.heading !== w.heading) report("heading", w.heading, got.heading);
			if (got.quat_z !== w.quat_z) report("quat_z", w.quat_z, got.quat_z);
			if (got.quat_w !== w.quat_w) report("quat_w", w.quat_w, got.quat_w);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	dspo_in_if in_ch();
	dspo_out_if out_ch();
	dspo_cfg_if cfg();

	dual_sensor_planar_odometry dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg(cfg.sink)
	);

	odo_scoreboard sb = new();
	bit quiet;
	bit hold_req;
	int items_sent;
	int stall_cnt = 0;
	bit signed [31:0] cur_fx, cur_fy, cur_sx, cur_sy;

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Note input transfers, check output transfers
	always @(posedge clk) begin
		pose_rec_t got;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_item(in_ch.first_x, in_ch.first_y, in_ch.second_x, in_ch.second_y);
			if (out_ch.valid && out_ch.ready) begin
				got.pose_x = out_ch.pose_x;
				got.pose_y = out_ch.pose_y;
				got.heading = out_ch.heading;
				got.quat_z = out_ch.quat_z;
				got.quat_w = out_ch.quat_w;
				sb.check_result(got);
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt > STALL_LIMIT) begin
			$display("timeout after %0d idle cycles", stall_cnt);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Result receiver: random stall bursts, one long hold on request
	initial begin
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	// Offer one sensor item and hold until its transfer
	task automatic send_item(bit signed [31:0] fx, bit signed [31:0] fy,
			bit signed [31:0] sx, bit signed [31:0] sy);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.first_x <= fx;
		in_ch.first_y <= fy;
		in_ch.second_x <= sx;
		in_ch.second_y <= sy;
		cur_fx = fx; cur_fy = fy; cur_sx = sx; cur_sy = sy;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
	endtask

	task automatic drop_valid();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for every pending pose, then let the pipeline drain
	task automatic drain();
		while (sb.want_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Offer one register write and hold until its transfer
	task automatic write_mount(logic [1:0] idx, logic [23:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		sb.set_mount(idx, val);
	endtask

	task automatic set_mounts(logic [23:0] ax, logic [23:0] ay, logic [23:0] bx,
			logic [23:0] by);
		write_mount(dspo_pkg::REG_MOUNT_A_X, ax);
		write_mount(dspo_pkg::REG_MOUNT_A_Y, ay);
		write_mount(dspo_pkg::REG_MOUNT_B_X, bx);
		write_mount(dspo_pkg::REG_MOUNT_B_Y, by);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int small_delta();
		int span;
		case ($urandom_range(0, 2))
			0: span = 16;
			1: span = 4096;
			default: span = 1 << 20;
		endcase
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Mostly smooth motion from the last readings, sometimes arbitrary jumps
	task automatic random_items(int count);
		int mx, my;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_item($urandom, $urandom, $urandom, $urandom);
			end else begin
				mx = small_delta();
				my = small_delta();
				send_item(cur_fx + mx + small_delta() / 64, cur_fy + my + small_delta() / 64,
					cur_sx + mx + small_delta() / 64, cur_sy + my + small_delta() / 64);
			end
		end
		drop_valid();
	endtask

	initial begin
		quiet = 1'b0;
		hold_req = 1'b0;
		items_sent = 0;
		cur_fx = 0; cur_fy = 0; cur_sx = 0; cur_sy = 0;
		arst_n = 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.first_x <= '0;
		in_ch.first_y <= '0;
		in_ch.second_x <= '0;
		in_ch.second_y <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= dspo_pkg::REG_MOUNT_A_X;
		cfg.data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero mounts after reset: zero baseline, first step measured from zero
		send_item(32'sd65536, 32'sd0, 32'sd65536, 32'sd0);
		send_item(32'sd65536, 32'sd0, 32'sd65536, 32'sd0);
		send_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_item(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		send_item(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
		send_item(32'sd0, 32'sd0, 32'sd0, 32'sd0);
		drop_valid();
		drain();

		// Sensors one metre either side of center
		set_mounts(24'hFF0000, 24'h000000, 24'h010000, 24'h000000);
		send_item(32'sd0, 32'sd0, 32'sd0, 32'sd0);
		send_item(32'sd0, -32'sd1000, 32'sd0, 32'sd1000);
		send_item(32'sd0, -32'sd100000, 32'sd0, 32'sd100000);
		send_item(32'sd0, -32'sd65536, 32'sd0, 32'sd200000);
		send_item(32'sd131072, -32'sd65536, 32'sd131072, 32'sd200000);
		send_item(32'sd131072, 32'sd0, 32'sd131072, 32'sd0);
		send_item(32'sd131072 - 32'sd300000, 32'sd0, 32'sd131072 + 32'sd300000, 32'sd0);
		send_item(-32'sd1, -32'sd1, -32'sd1, -32'sd1);
		send_item(32'h7FFFFFFF, 32'sd0, 32'h80000000, 32'sd0);
		send_item(32'h80000000, 32'sd0, 32'h7FFFFFFF, 32'sd0);
		drop_valid();
		drain();

		// Random motion with the receiver holding off for a long stretch
		hold_req = 1'b1;
		random_items(120);
		drain();

		// Extreme mounts, then coincident mounts for a zero baseline
		set_mounts(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000);
		random_items(90);
		drain();
		set_mounts(24'h123456, 24'hEDCBA9, 24'h123456, 24'hEDCBA9);
		random_items(60);
		drain();

		// Offset mounts, full-speed tail with no stalls
		set_mounts(24'h008000, 24'hFFC000, 24'hFF4000, 24'h00C000);
		random_items(110);
		quiet = 1'b1;
		random_items(60);
		drain();

		$display("Covered %0d sensor transfers and %0d pose results over five mount settings,",
			items_sent, sb.results_seen);
		$display("including a zero baseline, extreme mounts and a long output stall.");
		if (sb.errors == 0 && sb.want_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

/* filelist.f */
rtl/dspo_pkg.sv
rtl/dspo_if.sv
rtl/dspo_ctrl.sv
rtl/dspo_dp.sv
rtl/dual_sensor_planar_odometry.sv
bench/tb_top.sv
